// ----- hw/rtl/bzr_pkg.sv -----
// Shared types and constants for the cubic Bezier point evaluator.
`timescale 1ns / 1ps

package bzr_pkg;

    // Curve parameter is unsigned Q1.15; this code is t = 1.0.
    localparam int unsigned T_BITS = 16;
    localparam logic [T_BITS-1:0] T_ONE = 16'h8000;

    // Bernstein weights are exact integers in units of 2^-45.
    localparam int unsigned W_BITS  = 46;
    localparam int unsigned W_SHIFT = 45;
    // Weights are split here so that each coefficient product stays narrow.
    localparam int unsigned W_SPLIT = 23;

    localparam int unsigned NUM_POINTS     = 4;
    localparam int unsigned POINT_IDX_BITS = 2;
    localparam int unsigned CFG_INDEX_BITS = 3;

    // Register stages: squares, weights, partial products, product merge,
    // pair sums, rounding and saturated output.
    localparam int unsigned NUM_STAGES = 7;
    localparam int unsigned ST_SQUARE  = 0;
    localparam int unsigned ST_WEIGHT  = 1;
    localparam int unsigned ST_PART    = 2;
    localparam int unsigned ST_MERGE   = 3;
    localparam int unsigned ST_PAIR    = 4;
    localparam int unsigned ST_ROUND   = 5;
    localparam int unsigned ST_OUT     = 6;

    typedef logic [W_BITS-1:0] weight_t;
    typedef weight_t [NUM_POINTS-1:0] weight_vec_t;
    typedef logic [NUM_STAGES-1:0] stage_load_t;

endpackage

// ----- hw/rtl/bzr_weight.sv -----
// Two-stage Bernstein weight generator for the parameter t.
`timescale 1ns / 1ps

module bzr_weight (
    input  logic                         aclk,
    input  bzr_pkg::stage_load_t         stage_load,
    input  logic [bzr_pkg::T_BITS-1:0]   param_t,
    output bzr_pkg::weight_vec_t         weight
);
    import bzr_pkg::*;

    logic [T_BITS-1:0] t_clamp;
    logic [T_BITS-1:0] s_val;
    logic [T_BITS+1:0] t_triple;
    logic [31:0]       tt_next, ss_next, ts3_next, tt3_next;

    logic [T_BITS-1:0] t_reg, s_reg;
    logic [31:0]       tt_reg, ss_reg, ts3_reg, tt3_reg;

    logic [47:0]       w0_prod, w1_prod, w2_prod, w3_prod;
    weight_vec_t       weight_reg;

    // Clamp t to one, form s = 1 - t, 3t and the second-order products.
    always_comb begin
        t_clamp  = (param_t > T_ONE) ? T_ONE : param_t;
        s_val    = T_ONE - t_clamp;
        t_triple = {1'b0, t_clamp, 1'b0} + {2'b00, t_clamp};
        tt_next  = {16'h0000, t_clamp} * {16'h0000, t_clamp};
        ss_next  = {16'h0000, s_val} * {16'h0000, s_val};
        ts3_next = {14'h0000, t_triple} * {16'h0000, s_val};
        tt3_next = {14'h0000, t_triple} * {16'h0000, t_clamp};
    end

    always_ff @(posedge aclk) begin
        if (stage_load[ST_SQUARE]) begin
            t_reg   <= t_clamp;
            s_reg   <= s_val;
            tt_reg  <= tt_next;
            ss_reg  <= ss_next;
            ts3_reg <= ts3_next;
            tt3_reg <= tt3_next;
        end
    end

    // Third-order weights: s^3, 3ts^2, 3t^2s, t^3. All fit in 46 bits.
    always_comb begin
        w0_prod = {16'h0000, ss_reg} * {32'h0000_0000, s_reg};
        w1_prod = {16'h0000, ts3_reg} * {32'h0000_0000, s_reg};
        w2_prod = {16'h0000, tt3_reg} * {32'h0000_0000, s_reg};
        w3_prod = {16'h0000, tt_reg} * {32'h0000_0000, t_reg};
    end

    always_ff @(posedge aclk) begin
        if (stage_load[ST_WEIGHT]) begin
            weight_reg[0] <= w0_prod[W_BITS-1:0];
            weight_reg[1] <= w1_prod[W_BITS-1:0];
            weight_reg[2] <= w2_prod[W_BITS-1:0];
            weight_reg[3] <= w3_prod[W_BITS-1:0];
        end
    end

    assign weight = weight_reg;

endmodule

// ----- hw/rtl/bzr_axis_mac.sv -----
// Four-stage weighted sum with rounding for one coordinate axis.
`timescale 1ns / 1ps

module bzr_axis_mac #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                          aclk,
    input  bzr_pkg::stage_load_t          stage_load,
    input  bzr_pkg::weight_vec_t          weight,
    input  logic signed [COORD_BITS-1:0]  coord [bzr_pkg::NUM_POINTS],
    output logic signed [COORD_BITS+1:0]  rounded
);
    import bzr_pkg::*;

    localparam int unsigned PART_W = COORD_BITS + W_BITS - W_SPLIT + 1;
    localparam int unsigned SUM_W  = COORD_BITS + W_BITS + 2;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (W_SHIFT - 1);

    logic signed [PART_W-1:0] part_hi_reg [NUM_POINTS];
    logic signed [PART_W-1:0] part_lo_reg [NUM_POINTS];
    logic signed [SUM_W-1:0]  prod_reg [NUM_POINTS];
    logic signed [SUM_W-1:0]  pair_reg [2];
    logic signed [SUM_W-1:0]  total_next;
    logic signed [COORD_BITS+1:0] rounded_reg;

    // Coordinate times the upper and lower halves of each weight.
    always_ff @(posedge aclk) begin
        if (stage_load[ST_PART]) begin
            for (int i = 0; i < NUM_POINTS; i++) begin
                part_hi_reg[i] <= coord[i] * $signed({1'b0, weight[i][W_BITS-1:W_SPLIT]});
                part_lo_reg[i] <= coord[i] * $signed({1'b0, weight[i][W_SPLIT-1:0]});
            end
        end
    end

    // Recombine the halves into the full exact product.
    always_ff @(posedge aclk) begin
        if (stage_load[ST_MERGE]) begin
            for (int i = 0; i < NUM_POINTS; i++) begin
                prod_reg[i] <= (SUM_W'(part_hi_reg[i]) <<< W_SPLIT) + SUM_W'(part_lo_reg[i]);
            end
        end
    end

    // First level of the adder tree.
    always_ff @(posedge aclk) begin
        if (stage_load[ST_PAIR]) begin
            pair_reg[0] <= prod_reg[0] + prod_reg[1];
            pair_reg[1] <= prod_reg[2] + prod_reg[3];
        end
    end

    // Final sum plus one half, then floor by 2^45 (round half up).
    assign total_next = pair_reg[0] + pair_reg[1] + ROUND_HALF;

    always_ff @(posedge aclk) begin
        if (stage_load[ST_ROUND]) begin
            rounded_reg <= total_next[W_SHIFT +: COORD_BITS + 2];
        end
    end

    assign rounded = rounded_reg;

endmodule

// ----- hw/rtl/cubic_bezier_point_eval.sv -----
// Top level of the pipelined 3D cubic Bezier point evaluator.
`timescale 1ns / 1ps

// Evaluates a 3D cubic Bezier curve at t in unsigned Q1.15 (0x8000 = 1.0;
// larger codes are treated as 1.0). Each word on s_tdata yields exactly
// one point on m_tdata, in order. The datapath is a seven-register
// pipeline (squares, weights, partial products, product merge, pair
// sums, rounding, saturation); one word is accepted every clock while
// the downstream side keeps up, and stalls compress bubbles stage by
// stage. The four control points are written through the cfg port
// (index 0 to 3, x in the low COORD_BITS, then y, then z); write them
// only while the pipeline is empty. Results round to nearest, ties
// toward plus infinity.
module cubic_bezier_point_eval #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // Parameter words.
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    input  logic [15:0]                                  s_tdata,   // param_t
    // Curve point words.
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [((3*COORD_BITS+7)/8)*8-1:0]            m_tdata,   // pos_x, pos_y, pos_z
    // Control point writes.
    input  logic                                         cfg_valid,
    output logic                                         cfg_ready,
    input  logic [bzr_pkg::CFG_INDEX_BITS-1:0]           cfg_index,
    input  logic [3*COORD_BITS-1:0]                      cfg_data
);
    import bzr_pkg::*;

    localparam int unsigned OUT_W = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam logic signed [COORD_BITS+1:0] MAX_COORD =
        (COORD_BITS + 2)'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [COORD_BITS+1:0] MIN_COORD = -MAX_COORD - 1;

    logic [3*COORD_BITS-1:0]      ctrl_point_reg [NUM_POINTS];
    logic signed [COORD_BITS-1:0] axis_coord [3][NUM_POINTS];
    logic [NUM_STAGES-1:0]        valid_reg, valid_next;
    stage_load_t                  stage_load;
    weight_vec_t                  weight;
    logic signed [COORD_BITS+1:0] axis_rounded [3];
    logic [COORD_BITS-1:0]        axis_sat [3];
    logic [OUT_W-1:0]             out_word_next;
    logic [OUT_W-1:0]             out_word_reg;

    // Control point registers; writes beyond the last index are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_POINTS; i++) begin
                ctrl_point_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready && (cfg_index < CFG_INDEX_BITS'(NUM_POINTS))) begin
            ctrl_point_reg[cfg_index[POINT_IDX_BITS-1:0]] <= cfg_data;
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < NUM_POINTS; i++) begin
                axis_coord[a][i] = $signed(ctrl_point_reg[i][a*COORD_BITS +: COORD_BITS]);
            end
        end
    end

    // A stage loads when it is empty or its contents move on this cycle.
    always_comb begin
        stage_load[ST_OUT] = !valid_reg[ST_OUT] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_load[k] = !valid_reg[k] || stage_load[k+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (stage_load[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_load[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_load[0];

    bzr_weight u_weight (
        .aclk       (aclk),
        .stage_load (stage_load),
        .param_t    (s_tdata),
        .weight     (weight)
    );

    for (genvar a = 0; a < 3; a++) begin : g_axis
        bzr_axis_mac #(
            .COORD_BITS (COORD_BITS)
        ) u_mac (
            .aclk       (aclk),
            .stage_load (stage_load),
            .weight     (weight),
            .coord      (axis_coord[a]),
            .rounded    (axis_rounded[a])
        );
    end

    // Saturate each axis and pack x, y, z from the low bits up.
    always_comb begin
        out_word_next = '0;
        for (int a = 0; a < 3; a++) begin
            if (axis_rounded[a] > MAX_COORD) begin
                axis_sat[a] = MAX_COORD[COORD_BITS-1:0];
            end else if (axis_rounded[a] < MIN_COORD) begin
                axis_sat[a] = MIN_COORD[COORD_BITS-1:0];
            end else begin
                axis_sat[a] = axis_rounded[a][COORD_BITS-1:0];
            end
            out_word_next[a*COORD_BITS +: COORD_BITS] = axis_sat[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_load[ST_OUT]) begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_tvalid = valid_reg[ST_OUT];
    assign m_tdata  = out_word_reg;

endmodule

// ----- hw/rtl/bzr_checker.sv -----
// Port-level assertions for the Bezier evaluator, bound to the top level.
`timescale 1ns / 1ps

module bzr_checker #(
    parameter int unsigned COORD_BITS = 16
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((3*COORD_BITS+7)/8)*8-1:0]     m_tdata
);

    // A stalled output word stays valid and unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed or dropped while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // An empty pipeline after reset accepts input.
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // With the sink ready every stage advances, so input is never blocked.
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while output side is ready");

endmodule

bind cubic_bezier_point_eval bzr_checker #(
    .COORD_BITS (COORD_BITS)
) u_bzr_checker (.*);
